>>> rtl/fbss_pkg.sv
// ----------------------------------------------------------------------------
// fbss_pkg
// Shared types and constants of the framebuffer scroll/sprite unit.
// ----------------------------------------------------------------------------
package fbss_pkg;

    // command codes carried in s_axis_tuser
    typedef enum logic [2:0] {
        REQ_SCROLL_RIGHT = 3'd0,
        REQ_SCROLL_LEFT  = 3'd1,
        REQ_SCROLL_DOWN  = 3'd2,
        REQ_LORES        = 3'd3,
        REQ_HIRES        = 3'd4,
        REQ_DRAW         = 3'd5,
        REQ_READ         = 3'd6
    } req_t;

    // row datapath operations
    typedef enum logic [1:0] {
        ALU_PASS = 2'd0,
        ALU_SHR  = 2'd1,
        ALU_SHL  = 2'd2,
        ALU_DRAW = 2'd3
    } alu_op_t;

    typedef struct packed {
        alu_op_t op;
        logic    hires;
    } alu_ctrl_t;

    // horizontal scroll distance in pixels
    localparam int SCROLL_STEP = 4;

    // stream widths
    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 72;
    localparam int WORD_W    = 64;

endpackage

>>> rtl/monochrome_framebuffer_scroll_sprite_unit.sv
// ----------------------------------------------------------------------------
// monochrome_framebuffer_scroll_sprite_unit
// 1-bit framebuffer with 4-pixel horizontal scroll, scroll down, XOR sprite
// rows with collision, resolution switch and 64-pixel word readout.
// ----------------------------------------------------------------------------
// One item is processed at a time and each yields one result item. The
// framebuffer is a row-wide RAM (one row per entry) with a per-row valid bit,
// so reset and mode switches clear it at once with no clearing pass. Scroll
// right or left sweeps every row of the current mode, one read-modify-write
// per cycle; scroll down by n skips n rows; a draw first reduces x and y
// modulo the width and height by repeated subtraction and writes no row
// when its row lands below the bottom edge; a read fetches one row. Mode
// switch, unused code, sprite row index past the sprite size and out-of-range
// reads go straight to the result. A new item is taken while the previous
// result still waits in the output register.
module monochrome_framebuffer_scroll_sprite_unit #(
    parameter int HI_WIDTH    = 128,
    parameter int HI_HEIGHT   = 64,
    parameter int SPRITE_SIZE = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // scroll_rows[3:0], x_coord[11:4], y_coord[19:12], sprite_row_index[23:20],
    // sprite_bits[39:24], read_row[45:40], read_half[46], zero[47]
    input  logic [fbss_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // req_type[2:0]
    input  logic [fbss_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // collision[0], hires_mode[1], read_word[65:2], zero[71:66]
    output logic [fbss_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

    localparam int LO_WIDTH  = HI_WIDTH / 2;
    localparam int LO_HEIGHT = HI_HEIGHT / 2;
    localparam int AW        = $clog2(HI_HEIGHT);
    localparam int XW        = $clog2(HI_WIDTH);
    localparam int CW        = $clog2(HI_WIDTH + 1);
    localparam int HW        = $clog2(HI_HEIGHT + 1);
    localparam int WORD_W    = fbss_pkg::WORD_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_DRAW_WR,
        S_SWEEP,
        S_READ_RD,
        S_READ_WR,
        S_DONE
    } state_t;

    // input fields
    logic [3:0]             in_scroll;
    logic [7:0]             in_x;
    logic [7:0]             in_y;
    logic [3:0]             in_idx;
    logic [15:0]            in_bits;
    logic [5:0]             in_rrow;
    logic                   in_half;
    fbss_pkg::req_t         in_req;
    logic                   in_accept;

    assign in_scroll = s_axis_tdata[3:0];
    assign in_x      = s_axis_tdata[11:4];
    assign in_y      = s_axis_tdata[19:12];
    assign in_idx    = s_axis_tdata[23:20];
    assign in_bits   = s_axis_tdata[39:24];
    assign in_rrow   = s_axis_tdata[45:40];
    assign in_half   = s_axis_tdata[46];
    assign in_req    = fbss_pkg::req_t'(s_axis_tuser);

    // registers
    state_t                 state_reg, state_next;
    logic                   hires_reg, hires_next;
    logic                   coll_reg, coll_next;
    logic [HI_HEIGHT-1:0]   valid_reg, valid_next;
    logic                   rd_valid_reg, rd_valid_next;
    logic                   pend_reg, pend_next;
    logic [AW-1:0]          pend_addr_reg, pend_addr_next;
    logic [AW-1:0]          tgt_reg, tgt_next;
    logic [HW-1:0]          left_reg, left_next;
    logic [3:0]             n_reg, n_next;
    fbss_pkg::alu_op_t      op_reg, op_next;
    logic [7:0]             x_reg, x_next;
    logic [7:0]             y_reg, y_next;
    logic [3:0]             idx_reg, idx_next;
    logic [SPRITE_SIZE-1:0] bits_reg, bits_next;
    logic [5:0]             rrow_reg, rrow_next;
    logic                   half_reg, half_next;
    logic [WORD_W-1:0]      word_reg, word_next;
    logic                   m_valid_reg, m_valid_next;
    logic                   out_coll_reg, out_coll_next;
    logic                   out_hires_reg, out_hires_next;
    logic [WORD_W-1:0]      out_word_reg, out_word_next;

    // datapath
    logic [CW-1:0]          cur_w;
    logic [HW-1:0]          cur_h;
    logic [8:0]             py;
    logic                   ram_we, ram_re;
    logic [AW-1:0]          ram_waddr, ram_raddr;
    logic [HI_WIDTH-1:0]    ram_rdata;
    logic [HI_WIDTH-1:0]    old_row;
    logic [HI_WIDTH-1:0]    alu_row;
    logic                   alu_hit;
    fbss_pkg::alu_ctrl_t    alu_ctrl;
    logic [HI_WIDTH+127:0]  ext_row;

    assign cur_w = hires_reg ? CW'(HI_WIDTH) : CW'(LO_WIDTH);
    assign cur_h = hires_reg ? HW'(HI_HEIGHT) : HW'(LO_HEIGHT);
    assign py    = {1'b0, y_reg} + 9'(idx_reg);

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);

    // a row never written since the last clear reads as zero
    assign old_row  = ram_rdata & {HI_WIDTH{rd_valid_reg}};
    assign ext_row  = {old_row, 128'b0};
    assign alu_ctrl = '{op: op_reg, hires: hires_reg};

    fbss_ram #(
        .WIDTH(HI_WIDTH),
        .DEPTH(HI_HEIGHT)
    ) u_rows (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(alu_row),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    fbss_row_alu #(
        .HI_WIDTH   (HI_WIDTH),
        .SPRITE_SIZE(SPRITE_SIZE)
    ) u_alu (
        .ctrl   (alu_ctrl),
        .old_row(old_row),
        .x_pos  (x_reg[XW-1:0]),
        .sprite (bits_reg),
        .new_row(alu_row),
        .hit    (alu_hit)
    );

    always_comb begin
        state_next     = state_reg;
        hires_next     = hires_reg;
        coll_next      = coll_reg;
        valid_next     = valid_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        tgt_next       = tgt_reg;
        left_next      = left_reg;
        n_next         = n_reg;
        op_next        = op_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        idx_next       = idx_reg;
        bits_next      = bits_reg;
        rrow_next      = rrow_reg;
        half_next      = half_reg;
        word_next      = word_reg;
        out_coll_next  = out_coll_reg;
        out_hires_next = out_hires_reg;
        out_word_next  = out_word_reg;
        m_valid_next   = m_valid_reg && !m_axis_tready;
        ram_we         = 1'b0;
        ram_waddr      = pend_addr_reg;
        ram_re         = 1'b0;
        ram_raddr      = tgt_reg - AW'(n_reg);

        unique case (state_reg)
            S_IDLE: begin
                if (in_accept) begin
                    word_next  = '0;
                    x_next     = in_x;
                    y_next     = in_y;
                    idx_next   = in_idx;
                    bits_next  = in_bits[SPRITE_SIZE-1:0];
                    rrow_next  = in_rrow;
                    half_next  = in_half;
                    pend_next  = 1'b0;
                    tgt_next   = AW'(cur_h - HW'(1));
                    state_next = S_DONE;
                    unique case (in_req) inside
                        fbss_pkg::REQ_SCROLL_RIGHT, fbss_pkg::REQ_SCROLL_LEFT: begin
                            op_next    = (in_req == fbss_pkg::REQ_SCROLL_RIGHT) ?
                                         fbss_pkg::ALU_SHR : fbss_pkg::ALU_SHL;
                            n_next     = '0;
                            left_next  = cur_h;
                            state_next = S_SWEEP;
                        end
                        fbss_pkg::REQ_SCROLL_DOWN: begin
                            // height is at least 16, so n never reaches it
                            op_next    = fbss_pkg::ALU_PASS;
                            n_next     = in_scroll;
                            left_next  = cur_h - HW'(in_scroll);
                            state_next = S_SWEEP;
                        end
                        fbss_pkg::REQ_LORES, fbss_pkg::REQ_HIRES: begin
                            hires_next = (in_req == fbss_pkg::REQ_HIRES);
                            valid_next = '0;
                        end
                        fbss_pkg::REQ_DRAW: begin
                            op_next = fbss_pkg::ALU_DRAW;
                            if (in_idx < SPRITE_SIZE) begin
                                if (in_idx == 4'd0) begin
                                    coll_next = 1'b0;
                                end
                                state_next = S_REDUCE;
                            end
                        end
                        fbss_pkg::REQ_READ: begin
                            if ((in_rrow < cur_h) && (!in_half || (cur_w > CW'(WORD_W)))) begin
                                state_next = S_READ_RD;
                            end
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end

            // modulo by repeated subtraction, x and y in parallel
            S_REDUCE: begin
                if (x_reg >= cur_w) begin
                    x_next = x_reg - 8'(cur_w);
                end
                if (y_reg >= cur_h) begin
                    y_next = y_reg - 8'(cur_h);
                end
                if ((x_reg < cur_w) && (y_reg < cur_h)) begin
                    if (py >= cur_h) begin
                        state_next = S_DONE;
                    end else begin
                        ram_re         = 1'b1;
                        ram_raddr      = py[AW-1:0];
                        pend_addr_next = py[AW-1:0];
                        state_next     = S_DRAW_WR;
                    end
                end
            end

            S_DRAW_WR: begin
                ram_we     = 1'b1;
                coll_next  = coll_reg | alu_hit;
                state_next = S_DONE;
            end

            // descending sweep: read row tgt-n, write it to tgt in the next cycle
            S_SWEEP: begin
                ram_we = pend_reg;
                if (left_reg != '0) begin
                    ram_re         = 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = tgt_reg;
                    tgt_next       = tgt_reg - AW'(1);
                    left_next      = left_reg - HW'(1);
                end else begin
                    pend_next = 1'b0;
                    for (int i = 0; i < HI_HEIGHT; i++) begin
                        if (i < n_reg) begin
                            valid_next[i] = 1'b0;
                        end
                    end
                    state_next = S_DONE;
                end
            end

            S_READ_RD: begin
                ram_re     = 1'b1;
                ram_raddr  = AW'(rrow_reg);
                state_next = S_READ_WR;
            end

            S_READ_WR: begin
                word_next  = half_reg ? ext_row[HI_WIDTH+63 -: WORD_W]
                                      : ext_row[HI_WIDTH+127 -: WORD_W];
                state_next = S_DONE;
            end

            S_DONE: begin
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next   = 1'b1;
                    out_coll_next  = coll_reg;
                    out_hires_next = hires_reg;
                    out_word_next  = word_reg;
                    state_next     = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase

        if (ram_we) begin
            valid_next[ram_waddr] = 1'b1;
        end
    end

    assign rd_valid_next = ram_re ? valid_reg[ram_raddr] : rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            hires_reg   <= 1'b0;
            coll_reg    <= 1'b0;
            valid_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            hires_reg   <= hires_next;
            coll_reg    <= coll_next;
            valid_reg   <= valid_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
        rd_valid_reg  <= rd_valid_next;
        pend_addr_reg <= pend_addr_next;
        tgt_reg       <= tgt_next;
        left_reg      <= left_next;
        n_reg         <= n_next;
        op_reg        <= op_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        idx_reg       <= idx_next;
        bits_reg      <= bits_next;
        rrow_reg      <= rrow_next;
        half_reg      <= half_next;
        word_reg      <= word_next;
        out_coll_reg  <= out_coll_next;
        out_hires_reg <= out_hires_next;
        out_word_reg  <= out_word_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {6'b0, out_word_reg, out_hires_reg, out_coll_reg};

    // read and write in the same cycle never touch the same row
    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("row read and write collide");

    // writes stay inside the active display height
    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> ({1'b0, ram_waddr} < {1'b0, cur_h}))
        else $error("row write beyond current height");

    // a mode switch leaves every row cleared
    a_mode_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && ((in_req == fbss_pkg::REQ_LORES) || (in_req == fbss_pkg::REQ_HIRES)))
        |=> (valid_reg == '0))
        else $error("mode switch did not clear the buffer");

    // one item at a time: no acceptance in the cycle after an accept
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> !s_axis_tready)
        else $error("item accepted while busy");

endmodule

>>> rtl/fbss_ram.sv
// ----------------------------------------------------------------------------
// fbss_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fbss_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/fbss_row_alu.sv
// ----------------------------------------------------------------------------
// fbss_row_alu
// Row datapath: horizontal scroll, XOR sprite placement with collision, pass.
// ----------------------------------------------------------------------------
module fbss_row_alu #(
    parameter int HI_WIDTH    = 128,
    parameter int SPRITE_SIZE = 16
) (
    input  fbss_pkg::alu_ctrl_t          ctrl,
    input  logic [HI_WIDTH-1:0]          old_row,
    input  logic [$clog2(HI_WIDTH)-1:0]  x_pos,
    input  logic [SPRITE_SIZE-1:0]       sprite,
    output logic [HI_WIDTH-1:0]          new_row,
    output logic                         hit
);

    // pixel c sits at bit HI_WIDTH-1-c; low-res keeps only the left half
    localparam logic [HI_WIDTH-1:0] LO_MASK =
        {{(HI_WIDTH/2){1'b1}}, {(HI_WIDTH-HI_WIDTH/2){1'b0}}};

    logic [HI_WIDTH-1:0]             region_mask;
    logic [HI_WIDTH+SPRITE_SIZE-1:0] sprite_wide;
    logic [HI_WIDTH-1:0]             sprite_row;

    assign region_mask = ctrl.hires ? {HI_WIDTH{1'b1}} : LO_MASK;
    // pixels pushed past the right edge fall into the low SPRITE_SIZE bits
    assign sprite_wide = {sprite, {HI_WIDTH{1'b0}}} >> x_pos;
    assign sprite_row  = sprite_wide[HI_WIDTH+SPRITE_SIZE-1:SPRITE_SIZE] & region_mask;

    always_comb begin
        new_row = old_row;
        hit     = 1'b0;
        case (ctrl.op)
            fbss_pkg::ALU_SHR:  new_row = (old_row >> fbss_pkg::SCROLL_STEP) & region_mask;
            fbss_pkg::ALU_SHL:  new_row = (old_row << fbss_pkg::SCROLL_STEP) & region_mask;
            fbss_pkg::ALU_DRAW: begin
                new_row = old_row ^ sprite_row;
                hit     = |(old_row & sprite_row);
            end
            default:            new_row = old_row;
        endcase
    end

endmodule
